[rtl/bpd_pkg.sv]
// ----------------------------------------------------------------------------
// bpd_pkg
// Types, constants and helper functions of the tree page decoder.
// ----------------------------------------------------------------------------
package bpd_pkg;

	localparam int HDR_BYTES = 16;
	localparam int CRC_BYTES = 4;
	localparam logic [31:0] CRC_POLY = 32'h82F63B78;

	// parser phases
	localparam logic [2:0] PH_HEADER   = 3'd0;
	localparam logic [2:0] PH_LEAF_HDR = 3'd1;
	localparam logic [2:0] PH_LEAF_BDY = 3'd2;
	localparam logic [2:0] PH_INT_HDR  = 3'd3;
	localparam logic [2:0] PH_INT_BDY  = 3'd4;
	localparam logic [2:0] PH_DONE     = 3'd5;
	localparam logic [2:0] PH_UNKNOWN  = 3'd6;

	// summary status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_CORRUPT = 2'd2;

	// result kinds
	localparam logic KIND_ENTRY   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// register indexes
	localparam logic REG_LEAF = 1'b0;
	localparam logic REG_INT  = 1'b1;

	typedef struct packed {
		logic [31:0] stored_crc;
		logic [11:0] value_length;
		logic [11:0] key_length;
		logic [11:0] key_offset;
		logic [63:0] child_page;
		logic [15:0] entry_count;
		logic [15:0] entry_index;
		logic        page_type;
		logic [1:0]  status;
		logic        kind;
	} res_t;

	// reflected crc-32c, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// clamp to the 12-bit output range
	function automatic logic [11:0] sat12(input logic [32:0] v);
		return (v > 33'd4095) ? 12'hFFF : v[11:0];
	endfunction

endpackage

[rtl/btree_page_decoder.sv]
// ----------------------------------------------------------------------------
// btree_page_decoder
// Streaming parser for a crc-32c checked tree page.
// ----------------------------------------------------------------------------
// Page bytes enter on the s_ stream, one word per byte, s_tlast on the final
// byte of a page. Each complete leaf or internal entry leaves on the m_ stream
// as a descriptor (m_tuser low), and after the last byte a page summary
// (m_tuser high) carries the status: ok, out of range for a page shorter than
// the header, or corrupt for a crc mismatch, unknown type, overlong page or
// missing entries. Descriptors are provisional until the summary arrives.
// Leaf and internal type codes are set over the apb port (0x0 and 0x4); the
// user must write them only while the block is idle; the block itself does not
// enforce this. The type is latched when the header completes. Throughput is
// one byte per cycle while the output queue has room. A byte is registered in
// the input register, then the parser and crc update from it and push up to
// two results into a four-entry output queue, whose head is on m_tdata. A byte
// may carry both a descriptor and a summary, which then leave as two words.
// When the receiver stalls the queue fills and s_tready drops while a byte
// waits and fewer than two entries are free. Reset clears the parser to the
// start of a page, the queue to empty and the type codes to 1 and 2.
module btree_page_decoder import bpd_pkg::*; #(
	parameter int MAX_PAGE_BYTES = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tlast,   // last_byte
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// [1:0] status, [2] page_type, [18:3] entry_index, [34:19] entry_count,
	// [98:35] child_page, [110:99] key_offset, [122:111] key_length,
	// [134:123] value_length, [166:135] stored_crc, [167] zero
	output logic [167:0] m_tdata,
	output logic         m_tuser,   // kind
	// configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int PW = $clog2(MAX_PAGE_BYTES + 1);

	// configuration registers
	logic [7:0] leaf_code_q, int_code_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_code_q <= 8'd1;
			int_code_q  <= 8'd2;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_LEAF) leaf_code_q <= pwdata[7:0];
			else                      int_code_q  <= pwdata[7:0];
		end
	end

	assign prdata = {24'd0, (paddr[2] == REG_LEAF) ? leaf_code_q : int_code_q};

	// input register
	logic       in_v_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv;
	logic [2:0] q_cnt_q;

	assign adv      = in_v_s1 && (q_cnt_q <= 3'd2);
	assign s_tready = !in_v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else if (s_tready) begin
			in_v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// parser state
	logic [PW-1:0] pos_q, pos_n;
	logic [31:0]   crc_q, crc_n;
	logic [31:0]   hcrc_q, hcrc_n;
	logic [7:0]    type_q, type_n;
	logic [15:0]   count_q, count_n;
	logic [63:0]   fchild_q, fchild_n;
	logic [15:0]   done_q, done_n;
	logic [2:0]    phase_q, phase_n;
	logic [39:0]   fs_q, fs_n;
	logic [3:0]    fcnt_q, fcnt_n;
	logic [15:0]   klen_q, klen_n;
	logic [31:0]   vlen_q, vlen_n;
	logic [32:0]   left_q, left_n;
	logic [PW-1:0] estart_q, estart_n;
	logic [63:0]   child_q, child_n;
	logic          bad_q, bad_n;
	logic          pint_q, pint_n;

	res_t       res0, res1;
	logic [1:0] npush;

	always_comb begin
		logic          fin, restart;
		logic [2:0]    hdr_ph;
		logic [47:0]   full;
		logic [PW:0]   koff;
		logic [1:0]    st;
		res_t          desc, summ;

		pos_n = pos_q; crc_n = crc_q; hcrc_n = hcrc_q; type_n = type_q;
		count_n = count_q; fchild_n = fchild_q; done_n = done_q;
		phase_n = phase_q; fs_n = fs_q; fcnt_n = fcnt_q; klen_n = klen_q;
		vlen_n = vlen_q; left_n = left_q; estart_n = estart_q;
		child_n = child_q; bad_n = bad_q; pint_n = pint_q;
		fin = 1'b0; restart = 1'b0; hdr_ph = PH_LEAF_HDR;
		full = {byte_s1, fs_q};
		desc = '0; summ = '0; st = ST_OK;

		if (pos_q >= PW'(MAX_PAGE_BYTES)) begin
			bad_n = 1'b1;
		end else begin
			if (pos_q >= PW'(CRC_BYTES)) crc_n = crc_byte(crc_q, byte_s1);
			fcnt_n = fcnt_q + 4'd1;
			unique case (phase_q) inside
				PH_HEADER: begin
					if (pos_q[3:2] == 2'b00)
						hcrc_n[{pos_q[1:0], 3'b000} +: 8] = byte_s1;
					else if (pos_q[3:0] == 4'd4)
						type_n = byte_s1;
					else if (pos_q[3:1] == 3'b011)
						count_n[{pos_q[0], 3'b000} +: 8] = byte_s1;
					else if (pos_q[3])
						fchild_n[{pos_q[2:0], 3'b000} +: 8] = byte_s1;
					if (pos_q == PW'(HDR_BYTES - 1)) begin
						if (type_q == leaf_code_q) begin
							pint_n = 1'b0; restart = 1'b1; hdr_ph = PH_LEAF_HDR;
						end else if (type_q == int_code_q) begin
							pint_n = 1'b1; restart = 1'b1; hdr_ph = PH_INT_HDR;
						end else begin
							phase_n = PH_UNKNOWN;
						end
					end
				end
				PH_LEAF_HDR: begin
					if (fcnt_q == 4'd5) begin
						klen_n = full[15:0];
						vlen_n = full[47:16];
						left_n = {17'd0, full[15:0]} + {1'b0, full[47:16]};
						if (left_n == '0) fin = 1'b1;
						else              phase_n = PH_LEAF_BDY;
					end else begin
						fs_n[{fcnt_q[2:0], 3'b000} +: 8] = byte_s1;
					end
				end
				PH_INT_HDR: begin
					if (!fcnt_q[3]) begin
						child_n[{fcnt_q[2:0], 3'b000} +: 8] = byte_s1;
					end else if (!fcnt_q[0]) begin
						fs_n[7:0] = byte_s1;
					end else begin
						klen_n = {byte_s1, fs_q[7:0]};
						left_n = {17'd0, byte_s1, fs_q[7:0]};
						if (left_n == '0) fin = 1'b1;
						else              phase_n = PH_INT_BDY;
					end
				end
				PH_LEAF_BDY, PH_INT_BDY: begin
					left_n = left_q - 33'd1;
					if (left_n == '0) fin = 1'b1;
				end
				default: begin
				end
			endcase
			pos_n = pos_q + PW'(1);
		end

		// entry descriptor
		koff = {1'b0, estart_q} + (pint_q ? (PW+1)'(10) : (PW+1)'(6));
		desc.kind         = KIND_ENTRY;
		desc.status       = ST_OK;
		desc.page_type    = pint_q;
		desc.entry_index  = done_q;
		desc.entry_count  = count_q;
		desc.child_page   = pint_q ? child_n : 64'd0;
		desc.key_offset   = sat12(33'(koff));
		desc.key_length   = sat12({17'd0, klen_n});
		desc.value_length = pint_q ? 12'd0 : sat12({1'b0, vlen_n});
		desc.stored_crc   = hcrc_q;

		if (fin) begin
			done_n  = done_q + 16'd1;
			restart = 1'b1;
			hdr_ph  = pint_q ? PH_INT_HDR : PH_LEAF_HDR;
		end
		if (restart) begin
			estart_n = pos_q + PW'(1);
			klen_n = '0; vlen_n = '0; child_n = '0; fs_n = '0; left_n = '0;
			fcnt_n = '0;
			phase_n = (done_n >= count_n) ? PH_DONE : hdr_ph;
		end

		// page summary
		if (pos_n < PW'(HDR_BYTES))
			st = ST_RANGE;
		else if (bad_n || (~crc_n != hcrc_n) || (phase_n != PH_DONE))
			st = ST_CORRUPT;
		summ.kind        = KIND_SUMMARY;
		summ.status      = st;
		summ.page_type   = pint_n;
		summ.entry_index = done_n;
		summ.entry_count = count_n;
		summ.child_page  = fchild_n;
		summ.stored_crc  = hcrc_n;

		res0  = fin ? desc : summ;
		res1  = summ;
		npush = {1'b0, fin} + {1'b0, last_s1};

		// clear for the next page
		if (last_s1) begin
			pos_n = '0; crc_n = '1; hcrc_n = '0; type_n = '0; count_n = '0;
			fchild_n = '0; done_n = '0; phase_n = PH_HEADER; fs_n = '0;
			fcnt_n = '0; klen_n = '0; vlen_n = '0; left_n = '0; estart_n = '0;
			child_n = '0; bad_n = 1'b0; pint_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; crc_q <= '1; hcrc_q <= '0; type_q <= '0; count_q <= '0;
			fchild_q <= '0; done_q <= '0; phase_q <= PH_HEADER; fs_q <= '0;
			fcnt_q <= '0; klen_q <= '0; vlen_q <= '0; left_q <= '0;
			estart_q <= '0; child_q <= '0; bad_q <= 1'b0; pint_q <= 1'b0;
		end else if (adv) begin
			pos_q <= pos_n; crc_q <= crc_n; hcrc_q <= hcrc_n; type_q <= type_n;
			count_q <= count_n; fchild_q <= fchild_n; done_q <= done_n;
			phase_q <= phase_n; fs_q <= fs_n; fcnt_q <= fcnt_n; klen_q <= klen_n;
			vlen_q <= vlen_n; left_q <= left_n; estart_q <= estart_n;
			child_q <= child_n; bad_q <= bad_n; pint_q <= pint_n;
		end
	end

	// output queue
	res_t       q_mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic       pop;
	logic [1:0] push_n;
	res_t       head;

	assign pop    = m_tvalid && m_tready;
	assign push_n = adv ? npush : 2'd0;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) q_mem_q[wp_q] <= res0;
		if (push_n == 2'd2) q_mem_q[wp_q + 2'd1] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; q_cnt_q <= '0;
		end else begin
			wp_q    <= wp_q + push_n;
			rp_q    <= rp_q + {1'b0, pop};
			q_cnt_q <= q_cnt_q + {1'b0, push_n} - {2'd0, pop};
		end
	end

	assign head     = q_mem_q[rp_q];
	assign m_tvalid = (q_cnt_q != 3'd0);
	assign m_tuser  = head.kind;
	assign m_tdata  = {1'b0, head.stored_crc, head.value_length, head.key_length,
		head.key_offset, head.child_page, head.entry_count, head.entry_index,
		head.page_type, head.status};

endmodule

[rtl/bpd_checker.sv]
// ----------------------------------------------------------------------------
// bpd_checker
// Port-level checks of the tree page decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bpd_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [167:0] m_tdata,
	input logic         m_tuser,
	input logic         pready
);

	// a stalled word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	// descriptors carry no status
	a_desc_st: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[1:0] == 2'd0)
		else $error("descriptor with nonzero status");

	// summary status is a defined code
	a_sum_st: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[1:0] != 2'd3)
		else $error("summary status out of range");

	// descriptor key offset lies past the header
	a_koff: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[110:99] >= 12'd22)
		else $error("descriptor key offset inside header");

	// config port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind btree_page_decoder bpd_checker u_bpd_checker (
	.clk(clk), .arst_n(arst_n),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
	.m_tuser(m_tuser), .pready(pready)
);

[dv/tb_btree_page_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_btree_page_decoder
// Self-checking bench for the tree page decoder: builds leaf, internal, broken
// and noise pages with their crc-32c, streams them byte by byte under several
// idle and stall mixes, and checks every descriptor and summary against an
// in-bench page parser.
// ----------------------------------------------------------------------------
module tb_btree_page_decoder import bpd_pkg::*;;

	localparam int PAGE_MAX = 4096;
	localparam int CYCLE_LIMIT = 400000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;   // [7:0] data_byte
	logic         s_tlast;   // last_byte
	logic         m_tvalid;
	logic         m_tready;
	// [1:0] status, [2] page_type, [18:3] entry_index, [34:19] entry_count,
	// [98:35] child_page, [110:99] key_offset, [122:111] key_length,
	// [134:123] value_length, [166:135] stored_crc, [167] zero
	logic [167:0] m_tdata;
	logic         m_tuser;   // kind
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	btree_page_decoder u_top (.*);

	// clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// bench state
	int idle_pct;
	int stall_pct;
	int errs;
	int cycles;
	int words_sent;
	int pages_sent;
	int results_seen;
	res_t want_q[$];
	logic [7:0] page_q[$];

	// parser copy: type codes and per-page state
	logic [7:0]  leaf_code;
	logic [7:0]  int_code;
	logic [12:0] pg_pos;
	logic [31:0] run_crc;
	logic [31:0] hdr_crc;
	logic [7:0]  type_b;
	logic [15:0] decl_cnt;
	logic [63:0] first_child;
	logic [15:0] done_cnt;
	logic [2:0]  phase;
	logic [63:0] fshift;
	logic [15:0] key_len;
	logic [31:0] val_len;
	logic [32:0] left_cnt;
	logic [12:0] ent_start;
	logic [63:0] ent_child;
	logic        over_flag;
	logic        is_internal;

	function automatic logic [31:0] crc32c_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ 32'h82F63B78) : (r >> 1);
		end
		return r;
	endfunction

	function automatic logic [11:0] clamp12(input logic [32:0] v);
		return (v > 33'd4095) ? 12'hFFF : v[11:0];
	endfunction

	// append one byte to the page under construction
	task automatic add_byte(input logic [7:0] b);
		page_q = {page_q, b};
	endtask

	task automatic clear_page();
		pg_pos = '0;
		run_crc = '1;
		hdr_crc = '0;
		type_b = '0;
		decl_cnt = '0;
		first_child = '0;
		done_cnt = '0;
		phase = PH_HEADER;
		fshift = '0;
		key_len = '0;
		val_len = '0;
		left_cnt = '0;
		ent_start = '0;
		ent_child = '0;
		over_flag = 1'b0;
		is_internal = 1'b0;
	endtask

	task automatic push_result(input logic k, input logic [1:0] st, input logic [15:0] idx,
			input logic [63:0] child, input logic [32:0] koff, input logic [32:0] klen,
			input logic [32:0] vlen);
		res_t r;
		r.kind = k;
		r.status = st;
		r.page_type = is_internal;
		r.entry_index = idx;
		r.entry_count = decl_cnt;
		r.child_page = child;
		r.key_offset = clamp12(koff);
		r.key_length = clamp12(klen);
		r.value_length = clamp12(vlen);
		r.stored_crc = hdr_crc;
		want_q = {want_q, r};
	endtask

	task automatic open_entry(input logic [12:0] nxt, input logic [2:0] hdr_phase);
		ent_start = nxt;
		key_len = '0;
		val_len = '0;
		ent_child = '0;
		fshift = '0;
		left_cnt = '0;
		phase = (done_cnt >= decl_cnt) ? PH_DONE : hdr_phase;
	endtask

	task automatic close_entry(input logic [12:0] p);
		if (is_internal)
			push_result(KIND_ENTRY, ST_OK, done_cnt, ent_child, 33'(ent_start) + 33'd10,
				33'(key_len), 33'd0);
		else
			push_result(KIND_ENTRY, ST_OK, done_cnt, 64'd0, 33'(ent_start) + 33'd6,
				33'(key_len), 33'(val_len));
		done_cnt = done_cnt + 16'd1;
		open_entry(p + 13'd1, is_internal ? PH_INT_HDR : PH_LEAF_HDR);
	endtask

	// one accepted page byte through the parser copy
	task automatic parse_byte(input logic [7:0] b, input bit l);
		logic [12:0] p;
		logic [12:0] o;
		logic [1:0] st;
		p = pg_pos;
		if (p >= PAGE_MAX) begin
			over_flag = 1'b1;
		end else begin
			o = p - ent_start;
			if (p >= CRC_BYTES)
				run_crc = crc32c_step(run_crc, b);
			case (phase) inside
				PH_HEADER: begin
					if (p < 4)
						hdr_crc = hdr_crc | (32'(b) << (8 * p));
					else if (p == 4)
						type_b = b;
					else if (p == 6 || p == 7)
						decl_cnt = decl_cnt | (16'(b) << (8 * (p - 6)));
					else if (p >= 8 && p < 16)
						first_child = first_child | (64'(b) << (8 * (p - 8)));
					if (p == HDR_BYTES - 1) begin
						if (type_b == leaf_code) begin
							is_internal = 1'b0;
							open_entry(p + 13'd1, PH_LEAF_HDR);
						end else if (type_b == int_code) begin
							is_internal = 1'b1;
							open_entry(p + 13'd1, PH_INT_HDR);
						end else begin
							phase = PH_UNKNOWN;
						end
					end
				end
				PH_LEAF_HDR: begin
					fshift = fshift | (64'(b) << (8 * (o & 13'd7)));
					if (o >= 5) begin
						key_len = fshift[15:0];
						val_len = fshift[47:16];
						left_cnt = 33'(key_len) + 33'(val_len);
						if (left_cnt == 0)
							close_entry(p);
						else
							phase = PH_LEAF_BDY;
					end
				end
				PH_INT_HDR: begin
					if (o < 8) begin
						ent_child = ent_child | (64'(b) << (8 * o));
					end else begin
						fshift = fshift | (64'(b) << (8 * ((o - 13'd8) & 13'd1)));
						if (o >= 9) begin
							key_len = fshift[15:0];
							left_cnt = 33'(key_len);
							if (left_cnt == 0)
								close_entry(p);
							else
								phase = PH_INT_BDY;
						end
					end
				end
				PH_LEAF_BDY, PH_INT_BDY: begin
					left_cnt = left_cnt - 33'd1;
					if (left_cnt == 0)
						close_entry(p);
				end
				default: ;
			endcase
			pg_pos = p + 13'd1;
		end
		// page summary after the last byte
		if (l) begin
			if (pg_pos < HDR_BYTES)
				st = ST_RANGE;
			else if (over_flag || ~run_crc != hdr_crc || phase != PH_DONE)
				st = ST_CORRUPT;
			else
				st = ST_OK;
			push_result(KIND_SUMMARY, st, done_cnt, first_child, 33'd0, 33'd0, 33'd0);
			clear_page();
		end
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_v);
		if (errs < 40)
			$display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, exp_v);
		errs++;
	endtask

	// result checker, cycle limit
	res_t got_r;
	res_t exp_r;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, want_q.size());
			$display("DONE: errors detected");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			got_r.kind = m_tuser;
			got_r.status = m_tdata[1:0];
			got_r.page_type = m_tdata[2];
			got_r.entry_index = m_tdata[18:3];
			got_r.entry_count = m_tdata[34:19];
			got_r.child_page = m_tdata[98:35];
			got_r.key_offset = m_tdata[110:99];
			got_r.key_length = m_tdata[122:111];
			got_r.value_length = m_tdata[134:123];
			got_r.stored_crc = m_tdata[166:135];
			if (want_q.size() == 0) begin
				report("unexpected word", {63'd0, m_tuser}, 64'd0);
			end else begin
				exp_r = want_q.pop_front();
				if (got_r.kind !== exp_r.kind)
					report("kind", 64'(got_r.kind), 64'(exp_r.kind));
				if (got_r.status !== exp_r.status)
					report("status", 64'(got_r.status), 64'(exp_r.status));
				if (got_r.page_type !== exp_r.page_type)
					report("page_type", 64'(got_r.page_type), 64'(exp_r.page_type));
				if (got_r.entry_index !== exp_r.entry_index)
					report("entry_index", 64'(got_r.entry_index), 64'(exp_r.entry_index));
				if (got_r.entry_count !== exp_r.entry_count)
					report("entry_count", 64'(got_r.entry_count), 64'(exp_r.entry_count));
				if (got_r.child_page !== exp_r.child_page)
					report("child_page", got_r.child_page, exp_r.child_page);
				if (got_r.key_offset !== exp_r.key_offset)
					report("key_offset", 64'(got_r.key_offset), 64'(exp_r.key_offset));
				if (got_r.key_length !== exp_r.key_length)
					report("key_length", 64'(got_r.key_length), 64'(exp_r.key_length));
				if (got_r.value_length !== exp_r.value_length)
					report("value_length", 64'(got_r.value_length),
						64'(exp_r.value_length));
				if (got_r.stored_crc !== exp_r.stored_crc)
					report("stored_crc", 64'(got_r.stored_crc), 64'(exp_r.stored_crc));
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// send one word, idling first at random
	task automatic send_byte(input logic [7:0] b, input bit l);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= l;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		parse_byte(b, l);
	endtask

	task automatic send_page();
		for (int i = 0; i < page_q.size(); i++)
			send_byte(page_q[i], i == page_q.size() - 1);
		pages_sent++;
	endtask

	// stop sending and wait for every pending result, then let the pipe settle
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (want_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] v);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'(4 * idx);
		pwdata <= {24'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_LEAF)
			leaf_code = v;
		else
			int_code = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_codes(input logic [7:0] lc, input logic [7:0] ic);
		write_reg(REG_LEAF, lc);
		write_reg(REG_INT, ic);
	endtask

	// build a page with a valid crc: nent entries, declared count decl,
	// lengths up to maxlen, trail extra bytes, optional bad crc, cut to cut bytes
	task automatic build_page(input logic [7:0] tcode, input bit internal, input int nent,
			input int decl, input int maxlen, input int trail, input bit bad_crc,
			input int cut);
		logic [31:0] c;
		logic [63:0] child;
		int kl;
		int vl;
		page_q.delete();
		child = {$urandom, $urandom};
		repeat (4) add_byte(8'd0);
		add_byte(tcode);
		add_byte(8'($urandom));
		add_byte(decl[7:0]);
		add_byte(decl[15:8]);
		for (int i = 0; i < 8; i++) add_byte(child[8*i +: 8]);
		for (int e = 0; e < nent; e++) begin
			kl = $urandom_range(maxlen);
			vl = internal ? 0 : $urandom_range(maxlen);
			if (internal) begin
				child = {$urandom, $urandom};
				for (int i = 0; i < 8; i++) add_byte(child[8*i +: 8]);
				add_byte(kl[7:0]);
				add_byte(kl[15:8]);
			end else begin
				add_byte(kl[7:0]);
				add_byte(kl[15:8]);
				for (int i = 0; i < 4; i++) add_byte(vl[8*i +: 8]);
			end
			repeat (kl + vl) add_byte(8'($urandom));
		end
		repeat (trail) add_byte(8'($urandom));
		c = '1;
		for (int i = 4; i < page_q.size(); i++) c = crc32c_step(c, page_q[i]);
		c = ~c;
		if (bad_crc) c[$urandom_range(31)] ^= 1'b1;
		for (int i = 0; i < 4; i++) page_q[i] = c[8*i +: 8];
		if (cut > 0 && cut < page_q.size()) page_q = page_q[0:cut-1];
	endtask

	task automatic noise_page();
		page_q.delete();
		repeat ($urandom_range(1, 30)) add_byte(8'($urandom));
	endtask

	// short pages, every page kind and the crc, type and entry-count corrupt cases
	task automatic test_directed();
		build_page(leaf_code, 1'b0, 0, 0, 0, 0, 1'b0, 1); send_page();
		build_page(leaf_code, 1'b0, 2, 2, 3, 0, 1'b0, 15); send_page();
		build_page(leaf_code, 1'b0, 2, 2, 3, 0, 1'b0, 0); send_page();
		build_page(int_code, 1'b1, 2, 2, 2, 0, 1'b0, 0); send_page();
		build_page(int_code, 1'b1, 1, 1, 0, 0, 1'b0, 0); send_page();
		build_page(leaf_code, 1'b0, 1, 1, 2, 0, 1'b1, 0); send_page();
		build_page(8'h77, 1'b0, 1, 1, 2, 0, 1'b0, 0); send_page();
		build_page(leaf_code, 1'b0, 1, 2, 2, 0, 1'b0, 0); send_page();
		build_page(int_code, 1'b1, 2, 1, 1, 0, 1'b0, 0); send_page();
		build_page(int_code, 1'b1, 1, 1, 0, 0, 1'b0, 16); send_page();
		drain();
	endtask

	// equal codes give leaf; code extremes
	task automatic test_type_codes();
		set_codes(8'h00, 8'h00);
		build_page(8'h00, 1'b0, 1, 1, 2, 0, 1'b0, 0); send_page();
		drain();
		set_codes(8'hFF, 8'h00);
		build_page(8'hFF, 1'b0, 1, 1, 2, 0, 1'b0, 0); send_page();
		build_page(8'h00, 1'b1, 1, 1, 2, 0, 1'b0, 0); send_page();
		drain();
	endtask

	task automatic random_page();
		int r;
		int n;
		bit internal;
		r = $urandom_range(99);
		n = $urandom_range(2);
		internal = $urandom_range(1);
		if (r < 70)
			build_page(internal ? int_code : leaf_code, internal, n,
				($urandom_range(9) == 0) ? $urandom_range(3) : n, $urandom_range(3),
				($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0,
				$urandom_range(9) == 0, 0);
		else if (r < 80)
			build_page(internal ? int_code : leaf_code, internal, n, n, 3, 0, 1'b0,
				$urandom_range(1, 30));
		else if (r < 88)
			build_page(8'($urandom), internal, n, n, 2, 0, 1'b0, 0);
		else
			noise_page();
		send_page();
	endtask

	task automatic test_random_phase(input int idle_v, input int stall_v,
			input logic [7:0] lc, input logic [7:0] ic);
		set_codes(lc, ic);
		idle_pct = idle_v;
		stall_pct = stall_v;
		for (int i = 0; i < 2; i++) begin
			random_page();
			if (i == 0) drain();
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_pct = 0;
		stall_pct = 0;
		errs = 0;
		cycles = 0;
		words_sent = 0;
		pages_sent = 0;
		results_seen = 0;
		leaf_code = 8'd1;
		int_code = 8'd2;
		clear_page();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		idle_pct = 0;
		stall_pct = 0;
		test_directed();
		test_type_codes();
		test_random_phase(0, 0, 8'd1, 8'd2);
		test_random_phase(56, 0, 8'h00, 8'hFF);
		test_random_phase(0, 56, 8'hFF, 8'h00);
		test_random_phase(38, 38, 8'h5A, 8'hA5);

		while (want_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		errs += want_q.size();
		$display("covered %0d pages, %0d words in, %0d results out", pages_sent, words_sent,
			results_seen);
		$display("short, leaf, internal, unknown-type, bad-crc, truncated and noise pages");
		if (errs == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
